@@ design/kts_pkg.sv @@
// Package with the shared types, constants and codes of the keyframe track sampler.
`default_nettype none
package kts_pkg;
    localparam int MAX_KEYS   = 16;
    localparam int FRAME_BITS = 16;
    localparam int IDX_BITS   = $clog2(MAX_KEYS);
    localparam int CNT_BITS   = $clog2(MAX_KEYS + 1);
    localparam int VAL_BITS   = 32;
    localparam int NUM_COMP   = 4;
    localparam int T_BITS     = 17;

    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic signed [VAL_BITS-1:0] val_t;
    typedef val_t [NUM_COMP-1:0] vec_t;

    typedef enum logic [1:0] {
        KIND_CLEAR  = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_SAMPLE = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        SRC_DEFAULT = 3'd0,
        SRC_SINGLE  = 3'd1,
        SRC_FIRST   = 3'd2,
        SRC_LAST    = 3'd3,
        SRC_EXACT   = 3'd4,
        SRC_INTERP  = 3'd5
    } source_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } state_t;

    // Per-lane findings for one table slot.
    typedef struct packed {
        logic le;
        logic ge;
    } lane_t;
endpackage
`default_nettype wire

@@ design/kts_lane.sv @@
// One compare lane: tests a stored key frame against the query frame.
`default_nettype none
module kts_lane (
    input  wire logic              active,
    input  wire kts_pkg::frame_t   key_frame,
    input  wire kts_pkg::frame_t   query,
    output kts_pkg::lane_t         result
);
    always_comb begin
        result.le = active && (key_frame <= query);
        result.ge = active && (key_frame >= query);
    end
endmodule
`default_nettype wire

@@ design/kts_merge.sv @@
// Merges lane findings into the left and right bracket indexes.
`default_nettype none
module kts_merge (
    input  wire kts_pkg::lane_t [kts_pkg::MAX_KEYS-1:0] lanes,
    output logic                          left_found,
    output logic [kts_pkg::IDX_BITS-1:0]  left_idx,
    output logic                          right_found,
    output logic [kts_pkg::IDX_BITS-1:0]  right_idx
);
    always_comb begin
        left_found  = 1'b0;
        left_idx    = '0;
        right_found = 1'b0;
        right_idx   = '0;
        // Keys are sorted, so le lanes form a prefix and ge lanes a suffix.
        for (int i = 0; i < kts_pkg::MAX_KEYS; i++) begin
            if (lanes[i].le) begin
                left_found = 1'b1;
                left_idx   = kts_pkg::IDX_BITS'(i);
            end
            if (lanes[i].ge && !right_found) begin
                right_found = 1'b1;
                right_idx   = kts_pkg::IDX_BITS'(i);
            end
        end
    end
endmodule
`default_nettype wire

@@ design/keyframe_track_sampler.sv @@
// Top level of the keyframe track sampler.
`default_nettype none
// Holds up to 16 keys sorted by frame and answers one transaction at a time.
// A clear, an insert, or a sample that needs no interpolation passes through
// the SEARCH and OUT states. The search compares all slots at once in 16
// parallel lanes. An interpolating sample then runs a restoring divider, one
// quotient bit a cycle, and four component multiplies together in the MUL
// state before OUT. The result is held in an output register until taken, and
// the next transaction is accepted on the cycle after that at the earliest.
module keyframe_track_sampler (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [1:0]   s_tuser,   // kind
    input  wire logic [143:0] s_tdata,   // frame, in_x, in_y, in_z, in_w
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [0:0]        m_tuser,   // status
    output logic [135:0]      m_tdata,   // source, out_x, out_y, out_z, out_w, pad
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    localparam int N  = kts_pkg::MAX_KEYS;
    localparam int IB = kts_pkg::IDX_BITS;
    localparam int CB = kts_pkg::CNT_BITS;

    kts_pkg::state_t state_reg, state_next;
    kts_pkg::vec_t   dflt_reg;
    logic [CB-1:0]   count_reg;
    kts_pkg::frame_t frames_reg [N];
    kts_pkg::vec_t   vals_reg [N];

    kts_pkg::kind_t  kind_reg;
    kts_pkg::frame_t q_reg;
    kts_pkg::vec_t   inv_reg;
    logic [IB-1:0]   l_reg, r_reg;
    logic [31:0]     rem_reg, quo_reg, num_reg;
    logic [kts_pkg::FRAME_BITS-1:0] den_reg;
    logic [5:0]      step_reg;
    logic            m_valid_reg, status_reg;
    kts_pkg::source_t src_reg;
    kts_pkg::vec_t   out_reg;

    kts_pkg::lane_t [N-1:0] lanes;
    logic lf, rf;
    logic [IB-1:0] li, ri;
    logic accept;

    assign s_tready  = (state_reg == kts_pkg::ST_IDLE) && !m_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    for (genvar g = 0; g < N; g++) begin : g_lane
        kts_lane u_lane (
            .active    (CB'(g) < count_reg),
            .key_frame (frames_reg[g]),
            .query     (q_reg),
            .result    (lanes[g])
        );
    end

    kts_merge u_merge (
        .lanes(lanes), .left_found(lf), .left_idx(li),
        .right_found(rf), .right_idx(ri)
    );

    // Insert position: first active slot whose frame exceeds the new frame, else the key count.
    logic [CB-1:0] ins_pos;
    always_comb begin
        ins_pos = count_reg;
        for (int i = N - 1; i >= 0; i--) begin
            if (CB'(i) < count_reg && frames_reg[i] > q_reg) ins_pos = CB'(i);
        end
    end

    // Result fields chosen during the search cycle.
    logic             status_sel;
    kts_pkg::source_t src_sel;
    kts_pkg::vec_t    out_sel;
    always_comb begin
        status_sel = 1'b0;
        src_sel    = kts_pkg::SRC_DEFAULT;
        out_sel    = '0;
        unique case (kind_reg)
            kts_pkg::KIND_INSERT: status_sel = (count_reg == CB'(N));
            kts_pkg::KIND_SAMPLE: begin
                if (count_reg == '0) begin
                    out_sel = dflt_reg;
                end else if (count_reg == CB'(1)) begin
                    src_sel = kts_pkg::SRC_SINGLE;
                    out_sel = vals_reg[0];
                end else if (!lf) begin
                    src_sel = kts_pkg::SRC_FIRST;
                    out_sel = vals_reg[0];
                end else if (!rf) begin
                    src_sel = kts_pkg::SRC_LAST;
                    out_sel = vals_reg[IB'(count_reg - CB'(1))];
                end else if (li == ri || frames_reg[li] >= frames_reg[ri]) begin
                    src_sel = kts_pkg::SRC_EXACT;
                    out_sel = vals_reg[li];
                end else begin
                    src_sel = kts_pkg::SRC_INTERP;
                end
            end
            default: ;
        endcase
    end

    logic [32:0] rem_try;
    assign rem_try = {rem_reg, num_reg[31]} - {17'd0, den_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kts_pkg::ST_IDLE:   if (accept) state_next = kts_pkg::ST_SEARCH;
            kts_pkg::ST_SEARCH: begin
                if (kind_reg == kts_pkg::KIND_SAMPLE && count_reg >= CB'(2) && lf && rf
                    && li != ri && frames_reg[li] < frames_reg[ri]) begin
                    state_next = kts_pkg::ST_DIV;
                end else begin
                    state_next = kts_pkg::ST_OUT;
                end
            end
            kts_pkg::ST_DIV:    if (step_reg == 6'd31) state_next = kts_pkg::ST_MUL;
            kts_pkg::ST_MUL:    state_next = kts_pkg::ST_OUT;
            kts_pkg::ST_OUT:    state_next = kts_pkg::ST_IDLE;
            default:            state_next = kts_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kts_pkg::ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            dflt_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) dflt_reg[cfg_index] <= cfg_data;
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            unique case (state_reg)
                kts_pkg::ST_SEARCH: begin
                    status_reg <= status_sel;
                    src_reg    <= src_sel;
                    out_reg    <= out_sel;
                    l_reg      <= li;
                    r_reg      <= ri;
                    den_reg    <= frames_reg[ri] - frames_reg[li];
                    num_reg    <= {16'(q_reg - frames_reg[li]), 16'd0};
                    rem_reg    <= '0;
                    quo_reg    <= '0;
                    step_reg   <= '0;
                    unique case (kind_reg)
                        kts_pkg::KIND_CLEAR: count_reg <= '0;
                        kts_pkg::KIND_INSERT: begin
                            if (count_reg != CB'(N)) begin
                                for (int i = 1; i < N; i++) begin
                                    if (CB'(i) > ins_pos && CB'(i) <= count_reg) begin
                                        frames_reg[i] <= frames_reg[i-1];
                                        vals_reg[i]   <= vals_reg[i-1];
                                    end
                                end
                                frames_reg[ins_pos[IB-1:0]] <= q_reg;
                                vals_reg[ins_pos[IB-1:0]]   <= inv_reg;
                                count_reg <= count_reg + CB'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                kts_pkg::ST_DIV: begin
                    step_reg <= step_reg + 6'd1;
                    num_reg  <= {num_reg[30:0], 1'b0};
                    if (!rem_try[32]) begin
                        rem_reg <= rem_try[31:0];
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[30:0], num_reg[31]};
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                end
                kts_pkg::ST_MUL: begin
                    for (int c = 0; c < kts_pkg::NUM_COMP; c++) begin
                        logic signed [32:0] d;
                        logic signed [50:0] p;
                        d = 33'(vals_reg[r_reg][c]) - 33'(vals_reg[l_reg][c]);
                        p = d * $signed({1'b0, (quo_reg > 32'd65536) ? 17'h10000
                                                                       : quo_reg[16:0]});
                        out_reg[c] <= vals_reg[l_reg][c] + 32'(p >>> 16);
                    end
                end
                kts_pkg::ST_OUT: m_valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= kts_pkg::kind_t'(s_tuser);
            q_reg    <= s_tdata[15:0];
            inv_reg  <= {s_tdata[143:112], s_tdata[111:80], s_tdata[79:48], s_tdata[47:16]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {5'd0, out_reg[3], out_reg[2], out_reg[1], out_reg[0], src_reg};
endmodule
`default_nettype wire

@@ design/kts_checker.sv @@
// Port-level checker for the keyframe track sampler, bound to the top level.
`default_nettype none
module kts_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [1:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [0:0]   m_tuser,
    input wire logic [135:0] m_tdata
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_one_at_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result waits");
    a_no_src_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[2:0] == 3'd0)
        else $error("dropped key with a source");
    a_src_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] != 3'd6 && m_tdata[2:0] != 3'd7)
        else $error("bad source code");
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == 2'd0 |=> !s_tready)
        else $error("ready while busy");
endmodule

bind keyframe_track_sampler kts_checker u_kts_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tuser(m_tuser), .m_tdata(m_tdata)
);
`default_nettype wire
